// ===== sv/bocd_pkg.sv =====
// Shared types, constants and helper functions for the BER OID component decoder.
`timescale 1ns / 1ps

package bocd_pkg;

  // Field widths
  localparam int OCT_W   = 8;
  localparam int DIGIT_W = 7;
  localparam int ACC_W   = 32;

  // Component limit per identifier value and the counter that tracks it
  localparam int MAX_COMPONENTS = 128;
  localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);

  // First octet packs two arcs as first * ARC_DIV + second
  localparam int ARC_DIV = 40;
  localparam int ARC_QMAX = ((1 << OCT_W) - 1) / ARC_DIV;
  localparam int ARC_Q_W  = $clog2(ARC_QMAX + 1);

  // One accepted input transaction
  typedef struct packed {
    logic [OCT_W-1:0] octet;
    logic             first_octet;
    logic             last_octet;
    logic             primitive_req;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [ACC_W-1:0] component;
    logic             error;
    logic             done_res;
  } res_t;

  // Results produced by one octet: r0 always, r1 only when two is set
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pair_t;

  // Quotient of an octet by ARC_DIV: count of thresholds passed
  function automatic logic [ARC_Q_W-1:0] arc_quot(input logic [OCT_W-1:0] oct);
    logic [ARC_Q_W-1:0] q;
    q = '0;
    for (int i = 1; i <= ARC_QMAX; i++) begin
      if (oct >= OCT_W'(i * ARC_DIV)) begin
        q = q + 1'b1;
      end
    end
    return q;
  endfunction

  // Remainder of an octet by ARC_DIV, from the quotient
  function automatic logic [OCT_W-1:0] arc_rem(input logic [OCT_W-1:0] oct,
                                               input logic [ARC_Q_W-1:0] q);
    logic [OCT_W-1:0] prod;
    prod = OCT_W'(q) * OCT_W'(ARC_DIV);
    return oct - prod;
  endfunction

endpackage

// ===== sv/bocd_decode.sv =====
// Decode state (accumulator, component count, discard flag) and per-octet result logic.
`timescale 1ns / 1ps

module bocd_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  bocd_pkg::item_t item,
  output logic           push,
  output bocd_pkg::pair_t pair
);
  import bocd_pkg::*;

  logic [ACC_W-1:0] acc, acc_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             disc, disc_next;

  logic [ACC_W-1:0]   acc_sh;
  logic [CNT_W-1:0]   cnt_inc;
  logic [ARC_Q_W-1:0] quot;
  logic [OCT_W-1:0]   remd;
  logic               emit;
  res_t               err_res;

  assign acc_sh  = {acc[ACC_W-DIGIT_W-1:0], item.octet[DIGIT_W-1:0]};
  assign cnt_inc = cnt + 1'b1;
  assign quot    = arc_quot(item.octet);
  assign remd    = arc_rem(item.octet, quot);
  assign err_res = '{component: '0, error: 1'b1, done_res: 1'b1};

  // Next state and results for the octet in the input register
  always_comb begin
    acc_next  = acc;
    cnt_next  = cnt;
    disc_next = disc;
    pair      = '0;
    emit      = 1'b0;
    if (item.first_octet) begin
      disc_next = 1'b0;
      acc_next  = '0;
      emit      = 1'b1;
      if (!item.primitive_req) begin
        // constructed encoding is rejected
        pair.r0   = err_res;
        disc_next = !item.last_octet;
        cnt_next  = '0;
      end else begin
        pair.two  = 1'b1;
        pair.r0   = '{component: ACC_W'(quot), error: 1'b0, done_res: 1'b0};
        pair.r1   = '{component: ACC_W'(remd), error: 1'b0,
                      done_res: item.last_octet};
        cnt_next  = item.last_octet ? '0 : CNT_W'(2);
      end
    end else if (disc) begin
      // drop the rest of a failed value
      if (item.last_octet) begin
        disc_next = 1'b0;
      end
    end else if (acc[ACC_W-1 -: DIGIT_W] != '0) begin
      // shift would overflow
      emit      = 1'b1;
      pair.r0   = err_res;
      disc_next = !item.last_octet;
      acc_next  = '0;
      cnt_next  = '0;
    end else if (!item.octet[OCT_W-1]) begin
      // component ends here
      emit     = 1'b1;
      acc_next = '0;
      if (item.last_octet) begin
        pair.r0  = '{component: acc_sh, error: 1'b0, done_res: 1'b1};
        cnt_next = '0;
      end else if (cnt_inc >= CNT_W'(MAX_COMPONENTS)) begin
        pair.r0   = err_res;
        disc_next = 1'b1;
        cnt_next  = '0;
      end else begin
        pair.r0  = '{component: acc_sh, error: 1'b0, done_res: 1'b0};
        cnt_next = cnt_inc;
      end
    end else if (item.last_octet) begin
      // value ends inside a component
      emit     = 1'b1;
      pair.r0  = err_res;
      acc_next = '0;
      cnt_next = '0;
    end else begin
      acc_next = acc_sh;
    end
  end

  assign push = adv && emit;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      cnt  <= '0;
      disc <= 1'b0;
    end else if (adv) begin
      acc  <= acc_next;
      cnt  <= cnt_next;
      disc <= disc_next;
    end
  end

endmodule

// ===== sv/bocd_pair_queue.sv =====
// Two-entry queue of result pairs, drained one result transaction at a time.
`timescale 1ns / 1ps

module bocd_pair_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  bocd_pkg::pair_t          pair,
  output logic                     full,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [bocd_pkg::ACC_W-1:0] component,
  output logic                     error,
  output logic                     done_res
);
  import bocd_pkg::*;

  pair_t       q_mem [2];
  logic        wr_ptr, rd_ptr, sub;
  logic [1:0]  cnt;
  pair_t       head;
  res_t        cur;
  logic        pop;

  assign head      = q_mem[rd_ptr];
  assign cur       = sub ? head.r1 : head.r0;
  assign out_valid = (cnt != 2'd0);
  assign full      = (cnt == 2'd2);
  assign component = cur.component;
  assign error     = cur.error;
  assign done_res  = cur.done_res;

  // Entry retires once its last result transaction is taken
  assign pop = out_valid && !out_stall && (sub || !head.two);

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= pair;
    end
  end

  // Pointers, fill count, half select
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      sub    <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        sub    <= 1'b0;
      end else if (out_valid && !out_stall) begin
        sub <= 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== sv/ber_oid_component_decoder_unit.sv =====
// Top level of the BER object identifier component decoder.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall   | octet, first_octet, last_octet, primitive_req
//   out     | output    | out_valid/out_stall | component, error, done_res
//
// One octet per cycle while in_stall is low: an accepted octet is held in the input
// register, is decoded there, and its results enter a two-entry pair queue; the
// first result is visible the cycle after that. A first octet gives two result
// transactions, so the output port (one result a cycle while out_stall is low)
// sets the rate then. in_stall rises only while the input register holds an octet
// and the pair queue is full. Reset is synchronous, clears decode state and queue.
`timescale 1ns / 1ps

module ber_oid_component_decoder_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bocd_pkg::OCT_W-1:0] octet,
  input  logic                       first_octet,
  input  logic                       last_octet,
  input  logic                       primitive_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bocd_pkg::ACC_W-1:0] component,
  output logic                       error,
  output logic                       done_res
);
  import bocd_pkg::*;

  item_t item;
  logic  item_valid;
  logic  adv, accept, full, push;
  pair_t pair;

  assign adv      = item_valid && !full;
  assign in_stall = item_valid && full;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept || (item_valid && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= '{octet: octet, first_octet: first_octet,
                last_octet: last_octet, primitive_req: primitive_req};
    end
  end

  bocd_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (item),
    .push (push),
    .pair (pair)
  );

  bocd_pair_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pair      (pair),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .component (component),
    .error     (error),
    .done_res  (done_res)
  );

endmodule

// ===== tb/ber_oid_component_decoder_unit_test.sv =====
// Testbench for the BER OID component decoder: directed and random octet streams, self-checked.
`timescale 1ns / 1ps

module ber_oid_component_decoder_unit_test;
  import bocd_pkg::*;

  localparam int RANDOM_ITEMS   = 650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_MAX     = 10;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic [OCT_W-1:0] octet         = '0;
  logic             first_octet   = 1'b0;
  logic             last_octet    = 1'b0;
  logic             primitive_req = 1'b0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [ACC_W-1:0] component;
  logic             error;
  logic             done_res;

  // Octets waiting to be sent and results still owed by the decoder
  item_t pending_octets[$];
  res_t  expected_results[$];

  // Decoder state as the testbench tracks it
  logic [ACC_W-1:0] oid_acc          = '0;
  logic [CNT_W-1:0] arc_count        = '0;
  logic             value_discarding = 1'b0;

  item_t offered;
  int    send_gap       = 0;
  int    stall_left     = 0;
  int    items_accepted = 0;
  int    hold_left      = 0;
  int    holds_done     = 0;
  int    quiet_cycles   = 0;
  int    failures       = 0;
  logic  idle_ok        = 1'b1;

  ber_oid_component_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .octet         (octet),
    .first_octet   (first_octet),
    .last_octet    (last_octet),
    .primitive_req (primitive_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .component     (component),
    .error         (error),
    .done_res      (done_res)
  );

  always #4 clk = ~clk;

  // Stimulus helpers
  task automatic push_octet(input logic [OCT_W-1:0] o, input bit f, input bit l, input bit p);
    item_t it;
    it.octet         = o;
    it.first_octet   = f;
    it.last_octet    = l;
    it.primitive_req = p;
    pending_octets.push_back(it);
  endtask

  // Base-128 encoding, optionally with one redundant leading zero digit
  task automatic push_component(input logic [ACC_W-1:0] v, input bit is_last, input bit pad);
    int n;
    n = 1;
    while (n < 5 && (v >> (DIGIT_W * n)) != 0) n++;
    if (pad) n++;
    for (int i = n - 1; i >= 0; i--) begin
      push_octet({i != 0, DIGIT_W'(v >> (DIGIT_W * i))}, 1'b0, is_last && i == 0,
                 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic logic [ACC_W-1:0] rand_component();
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  // Well-formed value: first octet plus k components
  task automatic push_value(input logic [OCT_W-1:0] head, input int k);
    push_octet(head, 1'b1, k == 0, 1'b1);
    for (int j = 1; j <= k; j++) begin
      push_component(rand_component(), j == k, $urandom_range(0, 15) == 0);
    end
  endtask

  // Value of many one-octet components, around the component limit
  task automatic push_long_value(input int k);
    push_octet(8'($urandom), 1'b1, 1'b0, 1'b1);
    for (int j = 1; j <= k; j++) begin
      push_octet({1'b0, DIGIT_W'($urandom)}, 1'b0, j == k, 1'($urandom_range(0, 1)));
    end
  endtask

  // Expected-result bookkeeping
  task automatic owe_result(input logic [ACC_W-1:0] comp, input logic err, input logic done);
    res_t r;
    r.component = comp;
    r.error     = err;
    r.done_res  = done;
    expected_results.push_back(r);
  endtask

  task automatic reject_value(input logic is_last);
    owe_result('0, 1'b1, 1'b1);
    value_discarding = !is_last;
    oid_acc          = '0;
    arc_count        = '0;
  endtask

  // Predict the results of one accepted octet
  task automatic decode_octet(input item_t it);
    if (it.first_octet) begin
      value_discarding = 1'b0;
      oid_acc          = '0;
      if (!it.primitive_req) begin
        reject_value(it.last_octet);
      end else begin
        owe_result(ACC_W'(int'(it.octet) / ARC_DIV), 1'b0, 1'b0);
        owe_result(ACC_W'(int'(it.octet) % ARC_DIV), 1'b0, it.last_octet);
        arc_count = it.last_octet ? '0 : CNT_W'(2);
      end
    end else if (value_discarding) begin
      if (it.last_octet) value_discarding = 1'b0;
    end else if (oid_acc[ACC_W-1 -: DIGIT_W] != '0) begin
      // next shift would lose bits
      reject_value(it.last_octet);
    end else begin
      oid_acc = {oid_acc[ACC_W-DIGIT_W-1:0], it.octet[DIGIT_W-1:0]};
      if (!it.octet[OCT_W-1]) begin
        arc_count = arc_count + 1'b1;
        if (it.last_octet) begin
          owe_result(oid_acc, 1'b0, 1'b1);
          oid_acc   = '0;
          arc_count = '0;
        end else if (arc_count >= MAX_COMPONENTS) begin
          reject_value(1'b0);
        end else begin
          owe_result(oid_acc, 1'b0, 1'b0);
          oid_acc = '0;
        end
      end else if (it.last_octet) begin
        // value ends inside a component
        reject_value(1'b1);
      end
    end
  endtask

  // Driver: offers queued octets, predicts on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_octet(offered);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_octets.size() > 0) begin
          offered = pending_octets.pop_front();
          octet         <= offered.octet;
          first_octet   <= offered.first_octet;
          last_octet    <= offered.last_octet;
          primitive_req <= offered.primitive_req;
          in_valid      <= 1'b1;
          if (idle_ok && hold_left == 0 && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      // random gaps and stall bursts in all but every fourth block of 64, none near the end
      idle_ok <= ((items_accepted / 64) % 4 != 3) && (pending_octets.size() > 100);
    end
  end

  // Long receiver hold-off so the decoder fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && items_accepted >= 150) ||
                 (holds_done == 1 && items_accepted >= 450)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: checks each accepted result, drives random stall bursts
  always @(posedge clk) begin : monitor
    res_t want;
    logic burst;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= REPORT_MAX) begin
            $display("unexpected result: component %08h error %0b done %0b",
                     component, error, done_res);
          end
        end else begin
          want = expected_results.pop_front();
          if (component !== want.component || error !== want.error ||
              done_res !== want.done_res) begin
            failures++;
            if (failures <= REPORT_MAX) begin
              $display("mismatch: expected component %08h error %0b done %0b, got %08h %0b %0b",
                       want.component, want.error, want.done_res,
                       component, error, done_res);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        burst = 1'b1;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        burst      = 1'b1;
      end else begin
        burst = 1'b0;
      end
      out_stall <= burst || (hold_left != 0);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build the stimulus, run reset, wait for the drain, report
  initial begin
    int  directed_n;
    int  kind;
    int  n;
    bit  long_ok_done;
    bit  long_bad_done;
    long_ok_done  = 1'b0;
    long_bad_done = 1'b0;

    // 1.3.6.128
    push_octet(8'h2B, 1'b1, 1'b0, 1'b1);
    push_octet(8'h06, 1'b0, 1'b0, 1'b0);
    push_octet(8'h81, 1'b0, 1'b0, 1'b1);
    push_octet(8'h00, 1'b0, 1'b1, 1'b0);
    // single-octet values, the top bit of the first octet is part of the packed arcs
    push_octet(8'hFF, 1'b1, 1'b1, 1'b1);
    push_octet(8'h00, 1'b1, 1'b1, 1'b1);
    // constructed encoding, rest discarded
    push_octet(8'h2A, 1'b1, 1'b0, 1'b0);
    push_octet(8'h01, 1'b0, 1'b0, 1'b1);
    push_octet(8'h02, 1'b0, 1'b1, 1'b1);
    push_octet(8'h2A, 1'b1, 1'b1, 1'b0);
    // largest 32-bit component
    push_octet(8'h28, 1'b1, 1'b0, 1'b1);
    push_octet(8'h8F, 1'b0, 1'b0, 1'b0);
    push_octet(8'hFF, 1'b0, 1'b0, 1'b1);
    push_octet(8'hFF, 1'b0, 1'b0, 1'b0);
    push_octet(8'hFF, 1'b0, 1'b0, 1'b1);
    push_octet(8'h7F, 1'b0, 1'b1, 1'b0);
    // component overflows 32 bits
    push_octet(8'h50, 1'b1, 1'b0, 1'b1);
    push_octet(8'h90, 1'b0, 1'b0, 1'b1);
    push_octet(8'h80, 1'b0, 1'b0, 1'b0);
    push_octet(8'h80, 1'b0, 1'b0, 1'b1);
    push_octet(8'h80, 1'b0, 1'b0, 1'b0);
    push_octet(8'h80, 1'b0, 1'b0, 1'b1);
    push_octet(8'h7F, 1'b0, 1'b1, 1'b0);
    // last octet still continues
    push_octet(8'h2B, 1'b1, 1'b0, 1'b1);
    push_octet(8'hFF, 1'b0, 1'b1, 1'b1);
    // octets outside any value
    push_octet(8'h05, 1'b0, 1'b0, 1'b1);
    push_octet(8'h83, 1'b0, 1'b1, 1'b0);
    directed_n = pending_octets.size();

    while (pending_octets.size() < directed_n + RANDOM_ITEMS) begin
      if (!long_ok_done && pending_octets.size() > directed_n + 150) begin
        push_long_value($urandom_range(124, 126));
        long_ok_done = 1'b1;
      end else if (!long_bad_done && pending_octets.size() > directed_n + 400) begin
        push_long_value($urandom_range(127, 130));
        long_bad_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        push_value(8'($urandom), $urandom_range(0, 6));
      end else if (kind < 75) begin
        // constructed value with trailing octets
        n = $urandom_range(0, 3);
        push_octet(8'($urandom), 1'b1, n == 0, 1'b0);
        for (int j = 1; j <= n; j++) begin
          push_octet(8'($urandom), 1'b0, j == n, 1'($urandom_range(0, 1)));
        end
      end else if (kind < 82) begin
        // five-digit component with a high leading digit
        push_octet(8'($urandom), 1'b1, 1'b0, 1'b1);
        push_octet({1'b1, DIGIT_W'($urandom_range(16, 127))}, 1'b0, 1'b0, 1'b1);
        repeat (3) push_octet({1'b1, DIGIT_W'($urandom)}, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 3);
        for (int j = 1; j <= n; j++) begin
          push_octet(8'($urandom), 1'b0, j == n, 1'($urandom_range(0, 1)));
        end
      end else if (kind < 88) begin
        // value cut off inside a component
        push_octet(8'($urandom), 1'b1, 1'b0, 1'b1);
        n = $urandom_range(0, 3);
        for (int j = 1; j <= n; j++) begin
          push_component(rand_component(), 1'b0, 1'b0);
        end
        push_octet({1'b1, DIGIT_W'($urandom)}, 1'b0, 1'b1, 1'($urandom_range(0, 1)));
      end else if (kind < 94) begin
        // stray octets between values
        n = $urandom_range(1, 3);
        repeat (n) push_octet(8'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) push_octet(8'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_octets.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
